[rtl/core/mexp_pkg.sv]
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

	// default operand width and its legal range
	localparam int OPERAND_WIDTH = 31;
	localparam int OPERAND_WIDTH_MIN = 8;
	localparam int OPERAND_WIDTH_MAX = 63;

	// modulus after reset
	localparam int MODULUS_RESET = 2;

	// register index of the modulus
	localparam int REG_MODULUS = 0;

	// sequencer states
	typedef enum logic [2:0] {
		MEXP_IDLE,
		MEXP_REDUCE,
		MEXP_SQUARE,
		MEXP_MULT,
		MEXP_FINISH
	} mexp_state_t;

endpackage

`default_nettype wire

[rtl/core/mexp_if.sv]
// Valid/ready stream interfaces for operand words and residue words.
`default_nettype none

// operand word: base and exponent
interface mexp_in_if #(
	parameter int W = mexp_pkg::OPERAND_WIDTH
);
	logic         valid;
	logic         ready;
	logic [W-1:0] base_value;
	logic [W-1:0] exponent_value;

	modport source (output valid, output base_value, output exponent_value, input ready);
	modport sink (input valid, input base_value, input exponent_value, output ready);
endinterface

// residue word
interface mexp_out_if #(
	parameter int W = mexp_pkg::OPERAND_WIDTH
);
	logic         valid;
	logic         ready;
	logic [W-1:0] residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);
endinterface

`default_nettype wire

[rtl/core/modular_exponentiation.sv]
// Top level: square-and-multiply modular exponentiation with an APB modulus register.
//
// Takes a word of base and exponent and returns base^exponent mod modulus, scanning
// the exponent from its top bit down. Every modular product, and the initial reduction
// of the base, runs on one shared bit-serial multiply-reduce unit (W = OPERAND_WIDTH).
// When the modulus is below two the residue is 0 and no product is computed. The input
// is ready only while the sequencer is idle; a finished residue sits in an output
// register, so the next word may be taken while it waits. The modulus resets to 2 and is
// written at byte address 0 (8-byte stride when W > 32); it must be written only while
// no word is in flight, and the block itself does not enforce this.
`default_nettype none

module modular_exponentiation #(
	parameter int W = mexp_pkg::OPERAND_WIDTH,
	localparam int PDATA_W = (W > 32) ? 64 : 32,
	localparam int IDX_BIT = (W > 32) ? 3 : 2,
	localparam int ADDR_W  = IDX_BIT + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mexp_in_if.sink                 operands,
	mexp_out_if.source              results,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam int CNT_W = $clog2(W + 1);

	mexp_pkg::mexp_state_t state_q, state_d;

	logic [W-1:0]     modulus_q;
	logic [W-1:0]     base_q;
	logic [W-1:0]     exp_q;
	logic [W-1:0]     r_q;
	logic [W-1:0]     res_q;
	logic [CNT_W-1:0] bitcnt_q;
	logic             out_valid_q;

	logic         accept;
	logic         base_load;
	logic         r_load;
	logic [W-1:0] r_d;
	logic         bit_adv;
	logic         out_load;
	logic         last_bit;
	logic         reg_sel;

	logic         mm_start;
	logic [W-1:0] mm_x;
	logic [W-1:0] mm_y;
	logic         mm_busy;
	logic         mm_done;
	logic [W-1:0] mm_product;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[IDX_BIT] == 1'(mexp_pkg::REG_MODULUS));
	assign prdata  = reg_sel ? PDATA_W'(modulus_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(mexp_pkg::MODULUS_RESET);
		end else if (psel && penable && pwrite && reg_sel) begin
			modulus_q <= pwdata[W-1:0];
		end
	end

	// shared multiply-reduce unit
	mexp_modmul #(
		.W(W)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.x       (mm_x),
		.y       (mm_y),
		.m       (modulus_q),
		.busy    (mm_busy),
		.done    (mm_done),
		.product (mm_product)
	);

	assign operands.ready = (state_q == mexp_pkg::MEXP_IDLE);
	assign accept         = operands.valid && operands.ready;
	assign last_bit       = (bitcnt_q == CNT_W'(1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::MEXP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit commands
	always_comb begin
		state_d   = state_q;
		mm_start  = 1'b0;
		mm_x      = '0;
		mm_y      = '0;
		base_load = 1'b0;
		r_load    = 1'b0;
		r_d       = r_q;
		bit_adv   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			mexp_pkg::MEXP_IDLE: begin
				if (accept) begin
					if (modulus_q < W'(2)) begin
						r_load  = 1'b1;
						r_d     = '0;
						state_d = mexp_pkg::MEXP_FINISH;
					end else begin
						// base mod m computed as 1 * base mod m
						mm_start = 1'b1;
						mm_x     = W'(1);
						mm_y     = operands.base_value;
						state_d  = mexp_pkg::MEXP_REDUCE;
					end
				end
			end
			mexp_pkg::MEXP_REDUCE: begin
				if (mm_done) begin
					base_load = 1'b1;
					r_load    = 1'b1;
					r_d       = W'(1);
					mm_start  = 1'b1;
					mm_x      = W'(1);
					mm_y      = W'(1);
					state_d   = mexp_pkg::MEXP_SQUARE;
				end
			end
			mexp_pkg::MEXP_SQUARE: begin
				if (mm_done) begin
					r_load = 1'b1;
					r_d    = mm_product;
					if (exp_q[W-1]) begin
						mm_start = 1'b1;
						mm_x     = mm_product;
						mm_y     = base_q;
						state_d  = mexp_pkg::MEXP_MULT;
					end else begin
						bit_adv = 1'b1;
						if (last_bit) begin
							state_d = mexp_pkg::MEXP_FINISH;
						end else begin
							mm_start = 1'b1;
							mm_x     = mm_product;
							mm_y     = mm_product;
						end
					end
				end
			end
			mexp_pkg::MEXP_MULT: begin
				if (mm_done) begin
					r_load  = 1'b1;
					r_d     = mm_product;
					bit_adv = 1'b1;
					if (last_bit) begin
						state_d = mexp_pkg::MEXP_FINISH;
					end else begin
						mm_start = 1'b1;
						mm_x     = mm_product;
						mm_y     = mm_product;
						state_d  = mexp_pkg::MEXP_SQUARE;
					end
				end
			end
			mexp_pkg::MEXP_FINISH: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = mexp_pkg::MEXP_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::MEXP_IDLE;
			end
		endcase
	end

	// exponent bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
		end else if (accept) begin
			bitcnt_q <= CNT_W'(W);
		end else if (bit_adv) begin
			bitcnt_q <= bitcnt_q - CNT_W'(1);
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= operands.exponent_value;
		end else if (bit_adv) begin
			exp_q <= {exp_q[W-2:0], 1'b0};
		end
		if (base_load) begin
			base_q <= mm_product;
		end
		if (r_load) begin
			r_q <= r_d;
		end
		if (out_load) begin
			res_q <= r_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.residue = res_q;

	// the unit is never restarted while still stepping
	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_busy)
		else $error("multiply-reduce started while busy");

	// running value stays reduced during the exponent scan
	a_r_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::MEXP_SQUARE || state_q == mexp_pkg::MEXP_MULT)
		|-> (r_q < modulus_q))
		else $error("running value not below modulus");

	// a product only completes while the sequencer waits for one
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == mexp_pkg::MEXP_REDUCE || state_q == mexp_pkg::MEXP_SQUARE
			|| state_q == mexp_pkg::MEXP_MULT))
		else $error("unexpected product from multiply-reduce");

	// a word with a usable modulus goes to base reduction first
	a_accept_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && modulus_q >= W'(2)) |=> (state_q == mexp_pkg::MEXP_REDUCE))
		else $error("accepted word did not start base reduction");

	// a residue appears only out of the finish state
	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == mexp_pkg::MEXP_FINISH))
		else $error("residue raised outside finish");

endmodule

`default_nettype wire

[rtl/core/mexp_modmul.sv]
// Bit-serial modular multiplier: x*y mod m, one multiplier bit per cycle.
`default_nettype none

module mexp_modmul #(
	parameter int W = mexp_pkg::OPERAND_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] x,
	input  wire logic [W-1:0] y,
	input  wire logic [W-1:0] m,
	output logic              busy,
	output logic              done,
	output logic [W-1:0]      product
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     acc_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0]   m_ext;
	logic [W:0]   dbl;
	logic [W:0]   dbl_red;
	logic [W:0]   addend;
	logic [W:0]   sum;
	logic [W:0]   sum_red;

	// one step: acc = 2*acc mod m, then + x mod m when the multiplier bit is set
	always_comb begin
		m_ext   = {1'b0, m};
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		addend  = y_q[W-1] ? {1'b0, x_q} : '0;
		sum     = {1'b0, dbl_red[W-1:0]} + addend;
		sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator and operand shift register
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= sum_red[W-1:0];
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

[dv/modular_exponentiation_tb.sv]
// Self-checking testbench for the modular exponentiation block: stimulus, prediction, checks.

module modular_exponentiation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W          = mexp_pkg::OPERAND_WIDTH;
	localparam int PDATA_W    = (W > 32) ? 64 : 32;
	localparam int REG_STRIDE = (W > 32) ? 8 : 4;
	localparam int ADDR_W     = ((W > 32) ? 3 : 2) + 1;

	typedef logic [W-1:0]       operand_t;
	typedef logic [2*W-1:0]     product_t;
	typedef logic [PDATA_W-1:0] pdata_t;
	typedef logic [ADDR_W-1:0]  paddr_t;

	localparam operand_t OPERAND_MAX  = '1;
	localparam paddr_t   MODULUS_ADDR = paddr_t'(mexp_pkg::REG_MODULUS * REG_STRIDE);
	localparam paddr_t   UNUSED_ADDR  = paddr_t'((mexp_pkg::REG_MODULUS + 1) * REG_STRIDE);

	// output hold-off long enough to back up the input
	localparam int WORD_LATENCY    = 2100;
	localparam int HOLDOFF_CYCLES  = 6000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int RANDOM_PHASES   = 9;
	localparam int WORDS_PER_PHASE = 30;
	localparam longint TIMEOUT_NS  = 50_000_000;

	logic   clk;
	logic   arst_n;
	logic   psel;
	logic   penable;
	logic   pwrite;
	paddr_t paddr;
	pdata_t pwdata;
	pdata_t prdata;
	logic   pready;

	mexp_in_if  #(.W(W)) operands_if ();
	mexp_out_if #(.W(W)) results_if ();

	modular_exponentiation #(.W(W)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.results  (results_if),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// shadow of the modulus register and the residues still owed by the block
	operand_t modulus_shadow = operand_t'(mexp_pkg::MODULUS_RESET);
	operand_t pending_residues[$];

	int error_count      = 0;
	int words_sent       = 0;
	int residues_checked = 0;
	int modulus_settings = 0;

	// sender burst state and idling switches
	int burst_left     = 0;
	bit sender_gaps_on = 1'b1;
	bit rx_stalls_on   = 1'b1;
	bit holdoff_active = 1'b0;
	int rx_run_left    = 0;
	bit rx_ready_phase = 1'b1;
	event holdoff_go;

	// base^exponent mod m, right-to-left binary powering on double-width products
	function automatic operand_t modpow_residue(operand_t base_v, operand_t expo_v,
		operand_t m);
		product_t acc;
		product_t sq;
		if (m < 2)
			return '0;
		acc = product_t'(1);
		sq = product_t'(base_v) % product_t'(m);
		for (int k = 0; k < W; k++) begin
			if (expo_v[k])
				acc = (acc * sq) % product_t'(m);
			sq = (sq * sq) % product_t'(m);
		end
		return acc[W-1:0];
	endfunction

	function automatic operand_t pick_base(operand_t m);
		operand_t pick;
		case ($urandom_range(0, 9))
			4, 5: pick = (m < 2) ? operand_t'($urandom) : operand_t'($urandom_range(32'(m) - 1));
			6: pick = operand_t'($urandom_range(0, 1));
			7: pick = m - operand_t'(1);
			8: pick = m;
			9: pick = OPERAND_MAX;
			default: pick = operand_t'($urandom);
		endcase
		return pick;
	endfunction

	function automatic operand_t pick_exponent();
		operand_t pick;
		case ($urandom_range(0, 9))
			5: pick = operand_t'($urandom_range(0, 3));
			6: pick = OPERAND_MAX;
			7: pick = operand_t'($urandom) | (operand_t'(1) << (W - 1));
			8: pick = operand_t'($urandom) >> $urandom_range(0, W - 1);
			9: pick = operand_t'(1) << $urandom_range(0, W - 1);
			default: pick = operand_t'($urandom);
		endcase
		return pick;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hold-off of the residue side, counted in its own process
	initial begin
		forever begin
			@(holdoff_go);
			holdoff_active = 1'b1;
			repeat (HOLDOFF_CYCLES) @(posedge clk);
			holdoff_active = 1'b0;
		end
	end

	// residue side ready: alternating runs of stall and ready when stalls are on
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_active) begin
				results_if.ready <= 1'b0;
			end else if (!rx_stalls_on) begin
				results_if.ready <= 1'b1;
			end else begin
				if (rx_run_left == 0) begin
					rx_ready_phase = !rx_ready_phase;
					rx_run_left = rx_ready_phase ? $urandom_range(1, 30) : $urandom_range(1, 80);
				end
				rx_run_left--;
				results_if.ready <= rx_ready_phase;
			end
		end
	end

	// residue check against the oldest outstanding prediction
	always @(posedge clk) begin : check_residues
		operand_t want;
		if (results_if.valid && results_if.ready) begin
			if (pending_residues.size() == 0) begin
				$error("residue: unexpected word, got %0h", results_if.residue);
				error_count++;
			end else begin
				want = pending_residues.pop_front();
				residues_checked++;
				if (results_if.residue !== want) begin
					$error("residue: expected %0h, got %0h", want, results_if.residue);
					error_count++;
				end
			end
		end
	end

	// one word on the operand channel; prediction is queued at acceptance
	task automatic send_word(operand_t base_v, operand_t expo_v);
		int gap;
		operands_if.base_value     <= base_v;
		operands_if.exponent_value <= expo_v;
		operands_if.valid          <= 1'b1;
		do @(posedge clk); while (!operands_if.ready);
		pending_residues = {pending_residues, modpow_residue(base_v, expo_v, modulus_shadow)};
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			if (sender_gaps_on) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 2200) : $urandom_range(1, 8);
				operands_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering words and wait for every residue; the block is idle afterwards
	task automatic wait_for_residues();
		operands_if.valid <= 1'b0;
		while (pending_residues.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write_en, input paddr_t addr, input pdata_t wdata,
		output pdata_t rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write_en;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write the modulus; bits above the operand width are dropped by the block
	task automatic write_modulus(pdata_t value);
		pdata_t unused;
		apb_access(1'b1, MODULUS_ADDR, value, unused);
		modulus_shadow = value[W-1:0];
		modulus_settings++;
	endtask

	task automatic check_modulus_readback();
		pdata_t got;
		apb_access(1'b0, MODULUS_ADDR, '0, got);
		if (got !== pdata_t'(modulus_shadow)) begin
			$error("modulus readback: expected %0h, got %0h", modulus_shadow, got);
			error_count++;
		end
	endtask

	// modulus after reset, with a few words at modulus two
	task automatic test_reset_modulus();
		check_modulus_readback();
		send_word(operand_t'(5), operand_t'(3));
		send_word('0, '0);
		send_word(OPERAND_MAX, OPERAND_MAX);
		wait_for_residues();
	endtask

	// operand extremes at the largest modulus and at modulus two
	task automatic test_operand_extremes();
		write_modulus({1'b1, {(PDATA_W-1){1'b0}}} | pdata_t'(OPERAND_MAX));
		check_modulus_readback();
		send_word('0, '0);
		send_word('0, operand_t'(1));
		send_word('0, OPERAND_MAX);
		send_word(OPERAND_MAX, operand_t'(1));
		send_word(OPERAND_MAX, '0);
		send_word(OPERAND_MAX - operand_t'(1), OPERAND_MAX);
		send_word(operand_t'(1), OPERAND_MAX);
		send_word(operand_t'(2), operand_t'(W));
		send_word(operand_t'({(W/2+1){2'b01}}), operand_t'({(W/2+1){2'b10}}));
		send_word(operand_t'({(W/2+1){2'b10}}), operand_t'({(W/2+1){2'b01}}));
		wait_for_residues();
		write_modulus(pdata_t'(2));
		send_word(operand_t'(3), OPERAND_MAX);
		send_word(operand_t'(2), operand_t'(5));
		wait_for_residues();
	endtask

	// modulus of one and of zero give residue zero
	task automatic test_degenerate_modulus();
		write_modulus(pdata_t'(1));
		send_word(operand_t'(7), '0);
		send_word(OPERAND_MAX, OPERAND_MAX);
		wait_for_residues();
		write_modulus('0);
		check_modulus_readback();
		send_word('0, '0);
		send_word(operand_t'(5), operand_t'(3));
		wait_for_residues();
	endtask

	// write to an unmapped address must leave the modulus alone
	task automatic test_register_decode();
		pdata_t unused;
		write_modulus(pdata_t'(65537));
		apb_access(1'b1, UNUSED_ADDR, pdata_t'($urandom), unused);
		check_modulus_readback();
	endtask

	// long output hold-off while words keep coming, so the input backs up
	task automatic test_backpressure();
		write_modulus(pdata_t'($urandom | (1 << (W - 1)) | 1) & pdata_t'(OPERAND_MAX));
		sender_gaps_on = 1'b0;
		rx_stalls_on = 1'b1;
		-> holdoff_go;
		repeat (5) send_word(operand_t'($urandom), pick_exponent());
		wait_for_residues();
	endtask

	// random words over a series of moduli, idling off on every third phase
	task automatic test_random_moduli();
		pdata_t m;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: m = pdata_t'(OPERAND_MAX);
				1: m = pdata_t'(2);
				2: m = pdata_t'(3);
				3: m = pdata_t'($urandom | (1 << (W - 1)) | 1);
				4: m = pdata_t'($urandom_range(4, 255));
				5: m = pdata_t'(1) << $urandom_range(2, W - 1);
				6: m = pdata_t'(65537);
				7: m = pdata_t'($urandom);
				default: m = pdata_t'(($urandom | (1 << (W - 1))) & ~1);
			endcase
			// random junk in the excess bits
			m = (m & pdata_t'(OPERAND_MAX)) | (pdata_t'($urandom) & ~pdata_t'(OPERAND_MAX));
			wait_for_residues();
			write_modulus(m);
			check_modulus_readback();
			sender_gaps_on = (phase % 3) != 0;
			rx_stalls_on = (phase % 3) != 0;
			repeat (WORDS_PER_PHASE) send_word(pick_base(modulus_shadow), pick_exponent());
		end
		wait_for_residues();
	endtask

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("[modular_exponentiation] ERROR");
		$finish;
	end

	// main sequence
	initial begin
		arst_n                     <= 1'b0;
		psel                       <= 1'b0;
		penable                    <= 1'b0;
		pwrite                     <= 1'b0;
		paddr                      <= '0;
		pwdata                     <= '0;
		operands_if.valid          <= 1'b0;
		operands_if.base_value     <= '0;
		operands_if.exponent_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_modulus();
		test_operand_extremes();
		test_degenerate_modulus();
		test_register_decode();
		test_backpressure();
		test_random_moduli();

		// catch stray residues after the last expected one
		repeat (WORD_LATENCY) @(posedge clk);
		$display("Covered %0d words over %0d modulus settings, %0d residues checked.",
			words_sent, modulus_settings, residues_checked);
		$display("Included degenerate moduli, an unmapped write and a long output hold-off.");
		if (error_count == 0 && pending_residues.size() == 0) begin
			$display("[modular_exponentiation] OK");
		end else begin
			$display("[modular_exponentiation] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_modmul.sv
rtl/core/modular_exponentiation.sv
dv/modular_exponentiation_tb.sv
